// File: hw/rtl/sip_message_tokenizer_top_assert.svh
// assertion macros shared by the tokenizer modules
`ifndef SIP_MESSAGE_TOKENIZER_TOP_ASSERT_SVH
`define SIP_MESSAGE_TOKENIZER_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define SIPT_ASSERT_ALWAYS(label, ck, rn, cond) \
    label: assert property (@(posedge ck) disable iff (!rn) (cond)) \
        else $error("sipt: check failed");
`define SIPT_ASSERT_NEXT(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("sipt: check failed");
`else
`define SIPT_ASSERT_ALWAYS(label, ck, rn, cond)
`define SIPT_ASSERT_NEXT(label, ck, rn, ante, cons)
`endif
`endif

// File: hw/rtl/sipt_pkg.sv
package sipt_pkg;

    localparam int OFS_W = 13;

    typedef enum logic [2:0] {
        EV_LINE_DONE = 3'd0,
        EV_URI       = 3'd1,
        EV_HDR_NAME  = 3'd2,
        EV_VALUE     = 3'd3,
        EV_ERROR     = 3'd4
    } ev_kind_t;

    typedef enum logic [1:0] {
        METH_NONE     = 2'd0,
        METH_REGISTER = 2'd1,
        METH_UNKNOWN  = 2'd2
    } method_t;

    typedef struct packed {
        ev_kind_t         kind;
        logic [OFS_W-1:0] token_start;
        logic [OFS_W-1:0] token_len;
        logic [OFS_W-1:0] key_start;
        logic [OFS_W-1:0] key_len;
        logic             key_given;
        method_t          method_kind;
        logic             version_ok;
    } event_t;

    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_NL      = 8'h0A;
    localparam logic [7:0] CH_COLON   = 8'h3A;
    localparam logic [7:0] CH_EQUAL   = 8'h3D;
    localparam logic [7:0] CH_SEMI    = 8'h3B;
    localparam logic [7:0] CH_COMMA   = 8'h2C;
    localparam logic [7:0] CH_LANGLE  = 8'h3C;
    localparam logic [7:0] CH_RANGLE  = 8'h3E;
    localparam logic [7:0] CH_LSQUARE = 8'h5B;
    localparam logic [7:0] CH_RSQUARE = 8'h5D;

    localparam int REG_WORD_LEN = 8;
    localparam int VER_WORD_LEN = 7;

    // "REGISTER"
    function automatic logic [7:0] reg_char(input logic [2:0] idx);
        logic [7:0] c;
        unique case (idx)
            3'd0: c = 8'h52;
            3'd1: c = 8'h45;
            3'd2: c = 8'h47;
            3'd3: c = 8'h49;
            3'd4: c = 8'h53;
            3'd5: c = 8'h54;
            3'd6: c = 8'h45;
            3'd7: c = 8'h52;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // "SIP/2.0"
    function automatic logic [7:0] ver_char(input logic [2:0] idx);
        logic [7:0] c;
        unique case (idx)
            3'd0: c = 8'h53;
            3'd1: c = 8'h49;
            3'd2: c = 8'h50;
            3'd3: c = 8'h2F;
            3'd4: c = 8'h32;
            3'd5: c = 8'h2E;
            3'd6: c = 8'h30;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

// File: hw/rtl/sipt_in_stage.sv
module sipt_in_stage (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] data_byte,
    input  logic       end_of_message,
    input  logic       drain,
    output logic       held_valid,
    output logic [7:0] held_byte,
    output logic       held_eom
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;
    logic       eom_reg;

    assign in_ready = !valid_reg || drain;

    always_comb
    begin
        valid_next = valid_reg;
        if (in_ready)
        begin
            valid_next = in_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            byte_reg <= data_byte;
            eom_reg  <= end_of_message;
        end
    end

    assign held_valid = valid_reg;
    assign held_byte  = byte_reg;
    assign held_eom   = eom_reg;

endmodule

// File: hw/rtl/sipt_parser.sv
`include "sip_message_tokenizer_top_assert.svh"

module sipt_parser #(
    parameter int MAX_MESSAGE_BYTES = 4096
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step,
    input  logic [7:0]       data_byte,
    input  logic             eom,
    output logic             ev_valid,
    output sipt_pkg::event_t ev
);

    localparam int POS_W = $clog2(MAX_MESSAGE_BYTES + 1);
    localparam logic [POS_W-1:0] MAX_POS = POS_W'(MAX_MESSAGE_BYTES);
    localparam logic [POS_W-1:0] REG_LEN = POS_W'(sipt_pkg::REG_WORD_LEN);
    localparam logic [POS_W-1:0] VER_LEN = POS_W'(sipt_pkg::VER_WORD_LEN);

    logic              req_line_reg, req_line_next;
    sipt_pkg::method_t method_reg, method_next;
    logic              uri_seen_reg, uri_seen_next;
    logic              ver_seen_reg, ver_seen_next;
    logic              hdr_seen_reg, hdr_seen_next;
    logic              key_seen_reg, key_seen_next;
    logic              brackets_reg, brackets_next;
    logic              halted_reg, halted_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [POS_W-1:0]  tok_start_reg, tok_start_next;
    logic [POS_W-1:0]  key_start_reg, key_start_next;
    logic [POS_W-1:0]  key_len_reg, key_len_next;
    logic              reg_match_reg, reg_match_next;
    logic              ver_match_reg, ver_match_next;

    logic [POS_W-1:0]  tlen;
    logic              restart;
    logic              value_ev;
    sipt_pkg::ev_kind_t kind;
    logic [POS_W-1:0]  ev_ts, ev_tl, ev_ks, ev_kl;
    logic              ev_kg;
    logic              err_step;

    assign tlen = pos_reg - tok_start_reg;

    always_comb
    begin
        req_line_next   = req_line_reg;
        method_next     = method_reg;
        uri_seen_next   = uri_seen_reg;
        ver_seen_next   = ver_seen_reg;
        hdr_seen_next   = hdr_seen_reg;
        key_seen_next   = key_seen_reg;
        brackets_next   = brackets_reg;
        halted_next     = halted_reg;
        pos_next        = pos_reg;
        tok_start_next  = tok_start_reg;
        key_start_next  = key_start_reg;
        key_len_next    = key_len_reg;
        reg_match_next  = reg_match_reg;
        ver_match_next  = ver_match_reg;
        restart         = 1'b0;
        value_ev        = 1'b0;
        ev_valid        = 1'b0;
        kind            = sipt_pkg::EV_LINE_DONE;
        ev_ts           = '0;
        ev_tl           = '0;
        ev_ks           = '0;
        ev_kl           = '0;
        ev_kg           = 1'b0;

        if (!halted_reg && pos_reg < MAX_POS)
        begin
            priority if (data_byte == sipt_pkg::CH_SPACE)
            begin
                if (req_line_reg)
                begin
                    priority if (method_reg == sipt_pkg::METH_NONE)
                    begin
                        method_next = (reg_match_reg && tlen >= REG_LEN)
                            ? sipt_pkg::METH_REGISTER : sipt_pkg::METH_UNKNOWN;
                        restart = 1'b1;
                    end
                    else if (!uri_seen_reg)
                    begin
                        ev_valid      = 1'b1;
                        kind          = sipt_pkg::EV_URI;
                        ev_ts         = tok_start_reg;
                        ev_tl         = tlen;
                        uri_seen_next = 1'b1;
                        restart       = 1'b1;
                    end
                    else if (!ver_seen_reg)
                    begin
                        if (ver_match_reg && tlen >= VER_LEN)
                        begin
                            ver_seen_next = 1'b1;
                        end
                        restart = 1'b1;
                    end
                    else
                    begin
                        method_next = method_reg;
                    end
                end
            end
            else if (data_byte == sipt_pkg::CH_NL)
            begin
                if (req_line_reg)
                begin
                    if (!ver_seen_reg)
                    begin
                        if (ver_match_reg && tlen >= VER_LEN)
                        begin
                            ver_seen_next = 1'b1;
                        end
                        restart = 1'b1;
                    end
                    req_line_next = 1'b0;
                    ev_valid      = 1'b1;
                    kind          = sipt_pkg::EV_LINE_DONE;
                end
                else
                begin
                    value_ev      = 1'b1;
                    hdr_seen_next = 1'b0;
                    restart       = 1'b1;
                end
            end
            else if (!brackets_reg && data_byte == sipt_pkg::CH_COLON)
            begin
                if (!req_line_reg && !hdr_seen_reg)
                begin
                    ev_valid      = 1'b1;
                    kind          = sipt_pkg::EV_HDR_NAME;
                    ev_ts         = tok_start_reg;
                    ev_tl         = tlen;
                    hdr_seen_next = 1'b1;
                    restart       = 1'b1;
                end
            end
            else if (!brackets_reg && data_byte == sipt_pkg::CH_EQUAL)
            begin
                if (!key_seen_reg)
                begin
                    key_start_next = tok_start_reg;
                    key_len_next   = tlen;
                    key_seen_next  = 1'b1;
                    restart        = 1'b1;
                end
                else
                begin
                    ev_valid    = 1'b1;
                    kind        = sipt_pkg::EV_ERROR;
                    ev_ts       = pos_reg;
                    ev_ks       = key_start_reg;
                    ev_kl       = key_len_reg;
                    ev_kg       = 1'b1;
                    halted_next = 1'b1;
                end
            end
            else if (!brackets_reg && (data_byte == sipt_pkg::CH_SEMI ||
                                       data_byte == sipt_pkg::CH_COMMA))
            begin
                value_ev = 1'b1;
                restart  = 1'b1;
            end
            else if (data_byte == sipt_pkg::CH_LANGLE || data_byte == sipt_pkg::CH_LSQUARE)
            begin
                brackets_next = 1'b1;
            end
            else if (data_byte == sipt_pkg::CH_RANGLE || data_byte == sipt_pkg::CH_RSQUARE)
            begin
                brackets_next = 1'b0;
            end
            else
            begin
                brackets_next = brackets_reg;
            end

            if (value_ev)
            begin
                ev_valid      = 1'b1;
                kind          = sipt_pkg::EV_VALUE;
                ev_ts         = tok_start_reg;
                ev_tl         = tlen;
                key_seen_next = 1'b0;
                if (key_seen_reg)
                begin
                    ev_ks = key_start_reg;
                    ev_kl = key_len_reg;
                    ev_kg = 1'b1;
                end
            end

            if (restart)
            begin
                tok_start_next = pos_reg + POS_W'(1);
                reg_match_next = 1'b1;
                ver_match_next = 1'b1;
            end
            else
            begin
                if (tlen < REG_LEN && data_byte != sipt_pkg::reg_char(tlen[2:0]))
                begin
                    reg_match_next = 1'b0;
                end
                if (tlen < VER_LEN && data_byte != sipt_pkg::ver_char(tlen[2:0]))
                begin
                    ver_match_next = 1'b0;
                end
            end
            pos_next = pos_reg + POS_W'(1);
        end

        if (eom)
        begin
            req_line_next   = 1'b1;
            method_next     = sipt_pkg::METH_NONE;
            uri_seen_next   = 1'b0;
            ver_seen_next   = 1'b0;
            hdr_seen_next   = 1'b0;
            key_seen_next   = 1'b0;
            brackets_next   = 1'b0;
            halted_next     = 1'b0;
            pos_next        = '0;
            tok_start_next  = '0;
            key_start_next  = '0;
            key_len_next    = '0;
            reg_match_next  = 1'b1;
            ver_match_next  = 1'b1;
        end
    end

    // flags reported are those after this byte, before the end-of-message reset
    always_comb
    begin
        ev.kind        = kind;
        ev.token_start = sipt_pkg::OFS_W'(ev_ts);
        ev.token_len   = sipt_pkg::OFS_W'(ev_tl);
        ev.key_start   = sipt_pkg::OFS_W'(ev_ks);
        ev.key_len     = sipt_pkg::OFS_W'(ev_kl);
        ev.key_given   = ev_kg;
        ev.method_kind = method_reg;
        ev.version_ok  = ver_seen_reg;
        if (!halted_reg && pos_reg < MAX_POS && data_byte == sipt_pkg::CH_NL)
        begin
            ev.version_ok = ver_seen_reg || (req_line_reg && ver_match_reg &&
                                             tlen >= VER_LEN);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_line_reg   <= 1'b1;
            method_reg     <= sipt_pkg::METH_NONE;
            uri_seen_reg   <= 1'b0;
            ver_seen_reg   <= 1'b0;
            hdr_seen_reg   <= 1'b0;
            key_seen_reg   <= 1'b0;
            brackets_reg   <= 1'b0;
            halted_reg     <= 1'b0;
            pos_reg        <= '0;
            tok_start_reg  <= '0;
            key_start_reg  <= '0;
            key_len_reg    <= '0;
            reg_match_reg  <= 1'b1;
            ver_match_reg  <= 1'b1;
        end
        else if (step)
        begin
            req_line_reg   <= req_line_next;
            method_reg     <= method_next;
            uri_seen_reg   <= uri_seen_next;
            ver_seen_reg   <= ver_seen_next;
            hdr_seen_reg   <= hdr_seen_next;
            key_seen_reg   <= key_seen_next;
            brackets_reg   <= brackets_next;
            halted_reg     <= halted_next;
            pos_reg        <= pos_next;
            tok_start_reg  <= tok_start_next;
            key_start_reg  <= key_start_next;
            key_len_reg    <= key_len_next;
            reg_match_reg  <= reg_match_next;
            ver_match_reg  <= ver_match_next;
        end
    end

    assign err_step = step && ev_valid && kind == sipt_pkg::EV_ERROR && !eom;

    `SIPT_ASSERT_ALWAYS(a_pos_bound, clk, rst_n, pos_reg <= MAX_POS)
    `SIPT_ASSERT_ALWAYS(a_tok_before_pos, clk, rst_n, tok_start_reg <= pos_reg)
    `SIPT_ASSERT_NEXT(a_error_halts, clk, rst_n, err_step, halted_reg)

endmodule

// File: hw/rtl/sipt_out_stage.sv
module sipt_out_stage (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           load,
    input  sipt_pkg::event_t               ev,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [2:0]                     event_kind,
    output logic [sipt_pkg::OFS_W-1:0]     token_start,
    output logic [sipt_pkg::OFS_W-1:0]     token_len,
    output logic [sipt_pkg::OFS_W-1:0]     key_start,
    output logic [sipt_pkg::OFS_W-1:0]     key_len,
    output logic                           key_given,
    output logic [1:0]                     method_kind,
    output logic                           version_ok
);

    logic             valid_reg;
    logic             valid_next;
    sipt_pkg::event_t ev_reg;

    always_comb
    begin
        priority if (load)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            ev_reg <= ev;
        end
    end

    assign out_valid   = valid_reg;
    assign event_kind  = ev_reg.kind;
    assign token_start = ev_reg.token_start;
    assign token_len   = ev_reg.token_len;
    assign key_start   = ev_reg.key_start;
    assign key_len     = ev_reg.key_len;
    assign key_given   = ev_reg.key_given;
    assign method_kind = ev_reg.method_kind;
    assign version_ok  = ev_reg.version_ok;

endmodule

// File: hw/rtl/sip_message_tokenizer_top.sv
// a byte passes the input register, the parser and the result register that drives out_valid
// throughput: one byte per cycle if not stalled; single-pass parser between input/result regs
// a byte that yields a request waits while an unaccepted request sits in the result register
// bytes that cause no request are consumed without occupying the result register
// reset: rst_n asynchronous, active low; clears handshake flags and all parser state
// end_of_message returns the parser state to its reset values after that byte
`include "sip_message_tokenizer_top_assert.svh"

module sip_message_tokenizer_top #(
    parameter int MAX_MESSAGE_BYTES = 4096
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [7:0]                 data_byte,
    input  logic                       end_of_message,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [2:0]                 event_kind,
    output logic [sipt_pkg::OFS_W-1:0] token_start,
    output logic [sipt_pkg::OFS_W-1:0] token_len,
    output logic [sipt_pkg::OFS_W-1:0] key_start,
    output logic [sipt_pkg::OFS_W-1:0] key_len,
    output logic                       key_given,
    output logic [1:0]                 method_kind,
    output logic                       version_ok
);

    logic             held_valid;
    logic [7:0]       held_byte;
    logic             held_eom;
    logic             step;
    logic             ev_valid;
    sipt_pkg::event_t ev;
    logic             load;
    logic             keys_clear;

    assign step = held_valid && (!ev_valid || !out_valid || out_ready);
    assign load = step && ev_valid;

    sipt_in_stage u_in (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .data_byte      (data_byte),
        .end_of_message (end_of_message),
        .drain          (step),
        .held_valid     (held_valid),
        .held_byte      (held_byte),
        .held_eom       (held_eom)
    );

    sipt_parser #(
        .MAX_MESSAGE_BYTES (MAX_MESSAGE_BYTES)
    ) u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .data_byte (held_byte),
        .eom       (held_eom),
        .ev_valid  (ev_valid),
        .ev        (ev)
    );

    sipt_out_stage u_out (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (load),
        .ev          (ev),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .event_kind  (event_kind),
        .token_start (token_start),
        .token_len   (token_len),
        .key_start   (key_start),
        .key_len     (key_len),
        .key_given   (key_given),
        .method_kind (method_kind),
        .version_ok  (version_ok)
    );

    assign keys_clear = (key_start == '0) && (key_len == '0);

    `SIPT_ASSERT_ALWAYS(a_kind_range, clk, rst_n, !out_valid || event_kind <= 3'd4)
    `SIPT_ASSERT_ALWAYS(a_no_key_zero, clk, rst_n, !out_valid || key_given || keys_clear)
    `SIPT_ASSERT_ALWAYS(a_stall_no_load, clk, rst_n, !(out_valid && !out_ready) || !load)
    `SIPT_ASSERT_NEXT(a_stall_holds_request, clk, rst_n, out_valid && !out_ready, out_valid)

endmodule
